// File: src/tcce_pkg.sv
`default_nettype none
package tcce_pkg;

	// Largest segment on the wire; a write may fill it less the TCP header
	localparam int unsigned MAX_SEGMENT_BYTES = 1500;
	localparam logic [15:0] MAX_WRITE_BYTES = 16'(MAX_SEGMENT_BYTES - 20);

	localparam logic [15:0] PORT_FIRST = 16'd40000;
	localparam logic [31:0] ISN_MIX    = 32'h1F2E3D4C;
	localparam logic [15:0] MIN_SEG_BYTES = 16'd20;
	localparam logic [5:0]  MIN_HDR_BYTES = 6'd20;

	// Register reset values
	localparam logic [15:0] RETRY_INTERVAL_RST = 16'd100;
	localparam logic [2:0]  RETRY_LIMIT_RST    = 3'd5;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_PEER_ADDRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RMT_PORT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RETRY_INTVL  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT  = 2'd3;

	// Operation codes
	localparam logic [2:0] OP_CONNECT = 3'd0;
	localparam logic [2:0] OP_WRITE   = 3'd1;
	localparam logic [2:0] OP_CLOSE   = 3'd2;
	localparam logic [2:0] OP_SEGMENT = 3'd3;
	localparam logic [2:0] OP_TICK    = 3'd4;

	// Result kinds
	localparam logic [2:0] KIND_TRANSMIT  = 3'd0;
	localparam logic [2:0] KIND_DELIVER   = 3'd1;
	localparam logic [2:0] KIND_CONNECTED = 3'd2;
	localparam logic [2:0] KIND_CLOSED    = 3'd3;
	localparam logic [2:0] KIND_DONE      = 3'd4;

	// TCP flags
	localparam logic [7:0] FLAG_FIN = 8'h01;
	localparam logic [7:0] FLAG_SYN = 8'h02;
	localparam logic [7:0] FLAG_RST = 8'h04;
	localparam logic [7:0] FLAG_PSH = 8'h08;
	localparam logic [7:0] FLAG_ACK = 8'h10;

	// Plan queue between front and back
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] now_ticks;
		logic [15:0] length;
		logic [31:0] source_address;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [31:0] segment_seq;
		logic [7:0]  segment_flags;
		logic [3:0]  offset_words;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  tx_flags;
		logic [31:0] tx_seq;
		logic [31:0] tx_ack;
		logic        tx_with_mss;
		logic [15:0] payload_length;
		logic [5:0]  payload_offset;
		logic [15:0] own_port;
		logic        accepted;
		logic        active;
		logic        last;
	} out_item_t;

	// One segment to transmit
	typedef struct packed {
		logic        v;
		logic [7:0]  flags;
		logic [31:0] seq;
		logic [31:0] ack;
		logic        mss;
		logic [15:0] plen;
	} seg_t;

	// Everything the back end emits for one item, in emission order:
	// deliver, segment a, segment b, event, completion
	typedef struct packed {
		logic        del_v;
		logic [15:0] del_len;
		logic [5:0]  del_off;
		seg_t        seg_a;
		seg_t        seg_b;
		logic        ev_v;
		logic [2:0]  ev_kind;
		logic        accepted;
		logic        active;
		logic [15:0] own_port;
	} plan_t;

endpackage
`default_nettype wire

// File: src/tcce_channels.sv
`default_nettype none
interface tcce_in_if;
	logic                valid;
	logic                ready;
	tcce_pkg::in_item_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface tcce_out_if;
	logic                valid;
	logic                ready;
	tcce_pkg::out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: src/tcce_front.sv
`default_nettype none
module tcce_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	tcce_in_if.sink                            in_ch,
	input  wire logic                          cfg_we,
	input  wire logic [tcce_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                   cfg_data,
	output tcce_pkg::plan_t                    plan,
	output logic                               plan_valid,
	input  wire logic                          plan_ready
);

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_SYN_WAIT,
		CS_OPEN,
		CS_DONE
	} conn_state_t;

	// Configuration registers
	logic [31:0] peer_addr_q;
	logic [15:0] rmt_port_q;
	logic [15:0] retry_intvl_q;
	logic [2:0]  retry_limit_q;

	// Connection state
	conn_state_t state_q, state_d;
	logic [15:0] next_port_q, next_port_d;
	logic [15:0] local_port_q, local_port_d;
	logic [31:0] send_next_q, send_next_d;
	logic [31:0] recv_next_q, recv_next_d;
	logic [31:0] syn_time_q, syn_time_d;
	logic [2:0]  retry_cnt_q, retry_cnt_d;

	tcce_pkg::in_item_t it;
	tcce_pkg::plan_t    plan_d;
	logic               accept;

	// Segment classification
	logic [5:0]  hlen;
	logic [15:0] dlen;
	logic        seg_ok;
	logic        seq_match, fin_match;
	logic [31:0] rn_plus, rn_plus1, rn_inc, rn_after;
	logic [31:0] isn;
	logic [31:0] elapsed;
	logic [3:0]  retry_nxt;

	assign it         = in_ch.payload;
	assign accept     = in_ch.valid && plan_ready;
	assign in_ch.ready = plan_ready;
	assign plan_valid = in_ch.valid;
	assign plan       = plan_d;

	assign hlen      = {it.offset_words, 2'b00};
	assign dlen      = it.length - {10'b0, hlen};
	assign seg_ok    = (it.length >= tcce_pkg::MIN_SEG_BYTES) &&
			(it.source_address == peer_addr_q) &&
			(it.dest_port == local_port_q) && (it.source_port == rmt_port_q) &&
			(hlen >= tcce_pkg::MIN_HDR_BYTES) && ({10'b0, hlen} <= it.length);
	assign seq_match = (it.segment_seq == recv_next_q);
	assign fin_match = ((it.segment_seq + {16'b0, dlen}) == recv_next_q);
	assign rn_plus   = recv_next_q + {16'b0, dlen};
	assign rn_plus1  = recv_next_q + {16'b0, dlen} + 32'd1;
	assign rn_inc    = recv_next_q + 32'd1;
	assign rn_after  = ((dlen != 16'd0) && seq_match) ? rn_plus : recv_next_q;
	assign isn       = {it.now_ticks[23:0], 8'b0} ^ tcce_pkg::ISN_MIX;
	assign elapsed   = it.now_ticks - syn_time_q;
	assign retry_nxt = {1'b0, retry_cnt_q} + 4'd1;

	// Next state and result plan for the item at the input
	always_comb begin
		state_d      = state_q;
		next_port_d  = next_port_q;
		local_port_d = local_port_q;
		send_next_d  = send_next_q;
		recv_next_d  = recv_next_q;
		syn_time_d   = syn_time_q;
		retry_cnt_d  = retry_cnt_q;
		plan_d       = '0;

		case (it.operation)
			tcce_pkg::OP_CONNECT: begin
				local_port_d = next_port_q;
				next_port_d  = (next_port_q == 16'hFFFF) ? tcce_pkg::PORT_FIRST
						: next_port_q + 16'd1;
				recv_next_d  = '0;
				state_d      = CS_SYN_WAIT;
				syn_time_d   = it.now_ticks;
				retry_cnt_d  = '0;
				send_next_d  = isn + 32'd1;
				plan_d.seg_a = '{v: 1'b1, flags: tcce_pkg::FLAG_SYN, seq: isn,
						ack: 32'd0, mss: 1'b1, plen: 16'd0};
			end
			tcce_pkg::OP_WRITE: begin
				if (state_q == CS_OPEN && it.length <= tcce_pkg::MAX_WRITE_BYTES) begin
					plan_d.seg_a = '{v: 1'b1,
							flags: tcce_pkg::FLAG_PSH | tcce_pkg::FLAG_ACK,
							seq: send_next_q, ack: recv_next_q, mss: 1'b0,
							plen: it.length};
					send_next_d     = send_next_q + {16'b0, it.length};
					plan_d.accepted = 1'b1;
				end
			end
			tcce_pkg::OP_CLOSE: begin
				if (state_q == CS_OPEN) begin
					plan_d.seg_a = '{v: 1'b1,
							flags: tcce_pkg::FLAG_FIN | tcce_pkg::FLAG_ACK,
							seq: send_next_q, ack: recv_next_q, mss: 1'b0,
							plen: 16'd0};
					send_next_d = send_next_q + 32'd1;
				end
				state_d = CS_DONE;
			end
			tcce_pkg::OP_SEGMENT: begin
				if ((state_q == CS_SYN_WAIT || state_q == CS_OPEN) && seg_ok) begin
					if ((it.segment_flags & tcce_pkg::FLAG_RST) != 8'd0) begin
						state_d        = CS_DONE;
						plan_d.ev_v    = 1'b1;
						plan_d.ev_kind = tcce_pkg::KIND_CLOSED;
					end else if (state_q == CS_SYN_WAIT) begin
						// SYN+ACK completes the handshake
						if ((it.segment_flags & tcce_pkg::FLAG_SYN) != 8'd0 &&
								(it.segment_flags & tcce_pkg::FLAG_ACK) != 8'd0) begin
							recv_next_d  = it.segment_seq + 32'd1;
							state_d      = CS_OPEN;
							plan_d.seg_a = '{v: 1'b1, flags: tcce_pkg::FLAG_ACK,
									seq: send_next_q, ack: it.segment_seq + 32'd1,
									mss: 1'b0, plen: 16'd0};
							plan_d.ev_v    = 1'b1;
							plan_d.ev_kind = tcce_pkg::KIND_CONNECTED;
						end
					end else begin
						// established: in-order data is delivered, any data is acked
						if (dlen != 16'd0) begin
							if (seq_match) begin
								plan_d.del_v   = 1'b1;
								plan_d.del_len = dlen;
								plan_d.del_off = hlen;
							end
							recv_next_d  = rn_after;
							plan_d.seg_a = '{v: 1'b1, flags: tcce_pkg::FLAG_ACK,
									seq: send_next_q, ack: rn_after, mss: 1'b0,
									plen: 16'd0};
						end
						if ((it.segment_flags & tcce_pkg::FLAG_FIN) != 8'd0) begin
							recv_next_d = seq_match ? rn_plus1
									: (fin_match ? rn_inc : recv_next_q);
							plan_d.seg_b = '{v: 1'b1,
									flags: tcce_pkg::FLAG_FIN | tcce_pkg::FLAG_ACK,
									seq: send_next_q, ack: recv_next_d, mss: 1'b0,
									plen: 16'd0};
							send_next_d    = send_next_q + 32'd1;
							state_d        = CS_DONE;
							plan_d.ev_v    = 1'b1;
							plan_d.ev_kind = tcce_pkg::KIND_CLOSED;
						end
					end
				end
			end
			tcce_pkg::OP_TICK: begin
				if (state_q == CS_SYN_WAIT && elapsed >= {16'b0, retry_intvl_q}) begin
					syn_time_d  = it.now_ticks;
					retry_cnt_d = retry_nxt[2:0];
					if (retry_nxt > {1'b0, retry_limit_q}) begin
						state_d        = CS_DONE;
						plan_d.ev_v    = 1'b1;
						plan_d.ev_kind = tcce_pkg::KIND_CLOSED;
					end else begin
						plan_d.seg_a = '{v: 1'b1, flags: tcce_pkg::FLAG_SYN,
								seq: send_next_q - 32'd1, ack: recv_next_q, mss: 1'b1,
								plen: 16'd0};
					end
				end
			end
			default: begin
			end
		endcase

		plan_d.active   = (state_d == CS_SYN_WAIT) || (state_d == CS_OPEN);
		plan_d.own_port = local_port_d;
	end

	// State and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peer_addr_q   <= '0;
			rmt_port_q    <= '0;
			retry_intvl_q <= tcce_pkg::RETRY_INTERVAL_RST;
			retry_limit_q <= tcce_pkg::RETRY_LIMIT_RST;
			state_q       <= CS_IDLE;
			next_port_q   <= tcce_pkg::PORT_FIRST;
			local_port_q  <= '0;
			send_next_q   <= '0;
			recv_next_q   <= '0;
			syn_time_q    <= '0;
			retry_cnt_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tcce_pkg::REG_PEER_ADDRESS: peer_addr_q   <= cfg_data;
					tcce_pkg::REG_RMT_PORT:     rmt_port_q    <= cfg_data[15:0];
					tcce_pkg::REG_RETRY_INTVL:  retry_intvl_q <= cfg_data[15:0];
					tcce_pkg::REG_RETRY_LIMIT:  retry_limit_q <= cfg_data[2:0];
					default: begin
					end
				endcase
			end
			if (accept) begin
				state_q      <= state_d;
				next_port_q  <= next_port_d;
				local_port_q <= local_port_d;
				send_next_q  <= send_next_d;
				recv_next_q  <= recv_next_d;
				syn_time_q   <= syn_time_d;
				retry_cnt_q  <= retry_cnt_d;
			end
		end
	end

endmodule
`default_nettype wire

// File: src/tcce_queue.sv
`default_nettype none
module tcce_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tcce_pkg::plan_t push_data,
	input  wire logic            push_valid,
	output logic                 push_ready,
	output tcce_pkg::plan_t      pop_data,
	output logic                 pop_valid,
	input  wire logic            pop_ready
);

	tcce_pkg::plan_t                 entry_q [tcce_pkg::QDEPTH];
	logic [tcce_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [tcce_pkg::QCNT_W-1:0]     count_q;
	logic                            do_push, do_pop;

	assign push_ready = (count_q != tcce_pkg::QCNT_W'(tcce_pkg::QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Plan storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == tcce_pkg::QPTR_W'(tcce_pkg::QDEPTH - 1)) ? '0
						: wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == tcce_pkg::QPTR_W'(tcce_pkg::QDEPTH - 1)) ? '0
						: rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: src/tcce_back.sv
`default_nettype none
module tcce_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tcce_pkg::plan_t plan,
	input  wire logic            plan_valid,
	output logic                 plan_ready,
	tcce_out_if.source           out_ch
);

	// Pending results of the current plan: deliver, seg a, seg b, event, completion
	tcce_pkg::plan_t     cur_q;
	logic [4:0]          pend_q;
	tcce_pkg::out_item_t out_q;
	logic                out_v_q;

	tcce_pkg::out_item_t res;
	logic                adv, sel_done, load;

	assign adv        = (pend_q != 5'd0) && (!out_v_q || out_ch.ready);
	assign sel_done   = (pend_q == 5'b10000);
	assign load       = (pend_q == 5'd0) || (adv && sel_done);
	assign plan_ready = load;

	assign out_ch.valid   = out_v_q;
	assign out_ch.payload = out_q;

	// Next result: lowest pending entry
	always_comb begin
		res          = '0;
		res.own_port = cur_q.own_port;
		if (pend_q[0]) begin
			res.kind           = tcce_pkg::KIND_DELIVER;
			res.payload_length = cur_q.del_len;
			res.payload_offset = cur_q.del_off;
		end else if (pend_q[1]) begin
			res.kind           = tcce_pkg::KIND_TRANSMIT;
			res.tx_flags       = cur_q.seg_a.flags;
			res.tx_seq         = cur_q.seg_a.seq;
			res.tx_ack         = cur_q.seg_a.ack;
			res.tx_with_mss    = cur_q.seg_a.mss;
			res.payload_length = cur_q.seg_a.plen;
		end else if (pend_q[2]) begin
			res.kind           = tcce_pkg::KIND_TRANSMIT;
			res.tx_flags       = cur_q.seg_b.flags;
			res.tx_seq         = cur_q.seg_b.seq;
			res.tx_ack         = cur_q.seg_b.ack;
			res.tx_with_mss    = cur_q.seg_b.mss;
			res.payload_length = cur_q.seg_b.plen;
		end else if (pend_q[3]) begin
			res.kind = cur_q.ev_kind;
		end else begin
			res.kind     = tcce_pkg::KIND_DONE;
			res.accepted = cur_q.accepted;
			res.active   = cur_q.active;
			res.last     = 1'b1;
		end
	end

	// Current plan payload and output result register
	always_ff @(posedge clk) begin
		if (load && plan_valid) begin
			cur_q <= plan;
		end
		if (adv) begin
			out_q <= res;
		end
	end

	// Sequencing and output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				pend_q <= plan_valid ? {1'b1, plan.ev_v, plan.seg_b.v, plan.seg_a.v,
						plan.del_v} : 5'd0;
			end else if (adv) begin
				pend_q <= pend_q & (pend_q - 5'd1);
			end
			if (adv) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// File: src/tcp_client_connection_engine.sv
// Channel  Dir  Handshake     Payload
// in_ch    in   valid/ready   connect, write, close, segment header, tick
// out_ch   out  valid/ready   transmit, deliver, connected, closed, completion
// cfg      in   cfg_we only   peer address, peer port, retry interval, retry limit
//
// The front end classifies an item and updates connection state in the cycle it
// is accepted; it takes a new item every cycle while the two-entry plan queue has room.
// The back end emits one result per cycle from its output register unless out_ch stalls, so an
// item that yields n results (1 to 5, completion included) holds it until all n are emitted.
// Reset is asynchronous and needs no clearing pass; either side may stall freely.
`default_nettype none
module tcp_client_connection_engine (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	tcce_in_if.sink                            in_ch,
	tcce_out_if.source                         out_ch,
	input  wire logic                          cfg_we,
	input  wire logic [tcce_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                   cfg_data
);

	tcce_pkg::plan_t f_plan, q_plan;
	logic            f_valid, f_ready, q_valid, q_ready;

	tcce_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.plan       (f_plan),
		.plan_valid (f_valid),
		.plan_ready (f_ready)
	);

	tcce_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (f_plan),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.pop_data   (q_plan),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready)
	);

	tcce_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.plan       (q_plan),
		.plan_valid (q_valid),
		.plan_ready (q_ready),
		.out_ch     (out_ch)
	);

endmodule
`default_nettype wire

// File: src/tcce_checker.sv
`default_nettype none
module tcce_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [2:0] kind,
	input wire logic [7:0] tx_flags,
	input wire logic       tx_with_mss,
	input wire logic       last
);

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// Only the completion closes an item
	a_last_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> kind == tcce_pkg::KIND_DONE)
		else $error("last set on a non-completion result");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == tcce_pkg::KIND_DONE |-> last)
		else $error("completion without last");

	// MSS option rides only on SYN
	a_mss_syn: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_with_mss |-> kind == tcce_pkg::KIND_TRANSMIT &&
			tx_flags == tcce_pkg::FLAG_SYN)
		else $error("MSS option on a non-SYN result");

endmodule

bind tcp_client_connection_engine tcce_checker u_tcce_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.kind        (out_ch.payload.kind),
	.tx_flags    (out_ch.payload.tx_flags),
	.tx_with_mss (out_ch.payload.tx_with_mss),
	.last        (out_ch.payload.last)
);
`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps
module tb;
	import tcce_pkg::*;

	// Stall limit for the watchdog, in cycles with no item moving
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;

	typedef enum logic [1:0] {
		LINK_CLOSED,
		LINK_SYN_SENT,
		LINK_ESTABLISHED,
		LINK_DONE
	} link_state_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;

	tcce_in_if in_ch();
	tcce_out_if out_ch();

	tcp_client_connection_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Connection state as the engine should hold it
	link_state_t link_state;
	logic [15:0] port_pool;
	logic [15:0] own_port;
	logic [31:0] snd_nxt;
	logic [31:0] rcv_nxt;
	logic [31:0] syn_stamp;
	logic [2:0]  retry_tally;

	// Register copies
	logic [31:0] peer_ip;
	logic [15:0] rmt_port;
	logic [15:0] rto_ticks;
	logic [2:0]  rto_limit;

	out_item_t outstanding_results[$];
	int mismatches = 0;
	int items_sent = 0;
	bit idle_on = 1'b1;
	bit hold_request = 1'b0;

	task automatic reset_model();
		link_state = LINK_CLOSED;
		port_pool = PORT_FIRST;
		own_port = '0;
		snd_nxt = '0;
		rcv_nxt = '0;
		syn_stamp = '0;
		retry_tally = '0;
		peer_ip = '0;
		rmt_port = '0;
		rto_ticks = RETRY_INTERVAL_RST;
		rto_limit = RETRY_LIMIT_RST;
	endtask

	task automatic push_result(input logic [2:0] kind, input logic [7:0] flags,
			input logic [31:0] seq, input logic [31:0] ack, input logic mss,
			input logic [15:0] plen, input logic [5:0] poff, input logic acc,
			input logic act, input logic fin);
		out_item_t r;
		r.kind = kind;
		r.tx_flags = flags;
		r.tx_seq = seq;
		r.tx_ack = ack;
		r.tx_with_mss = mss;
		r.payload_length = plen;
		r.payload_offset = poff;
		r.own_port = own_port;
		r.accepted = acc;
		r.active = act;
		r.last = fin;
		outstanding_results.push_back(r);
	endtask

	task automatic push_segment(input logic [7:0] flags, input logic [31:0] seq,
			input logic mss, input logic [15:0] plen);
		push_result(KIND_TRANSMIT, flags, seq, rcv_nxt, mss, plen, '0, 1'b0, 1'b0, 1'b0);
	endtask

	task automatic push_event(input logic [2:0] kind);
		push_result(kind, '0, '0, '0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0);
	endtask

	// Received segment header
	task automatic take_segment(input in_item_t it);
		logic [15:0] hlen;
		logic [15:0] dlen;
		logic [31:0] tail;
		hlen = {10'd0, it.offset_words, 2'b00};
		if (link_state == LINK_CLOSED || link_state == LINK_DONE)
			return;
		if (it.length < MIN_SEG_BYTES || it.source_address != peer_ip)
			return;
		if (it.dest_port != own_port || it.source_port != rmt_port)
			return;
		if (hlen < 16'(MIN_HDR_BYTES) || hlen > it.length)
			return;
		dlen = it.length - hlen;
		if ((it.segment_flags & FLAG_RST) != 0) begin
			link_state = LINK_DONE;
			push_event(KIND_CLOSED);
			return;
		end
		if (link_state == LINK_SYN_SENT) begin
			if ((it.segment_flags & FLAG_SYN) != 0 && (it.segment_flags & FLAG_ACK) != 0) begin
				rcv_nxt = it.segment_seq + 32'd1;
				link_state = LINK_ESTABLISHED;
				push_segment(FLAG_ACK, snd_nxt, 1'b0, 16'd0);
				push_event(KIND_CONNECTED);
			end
			return;
		end
		if (dlen != 0) begin
			if (it.segment_seq == rcv_nxt) begin
				rcv_nxt += {16'd0, dlen};
				push_result(KIND_DELIVER, '0, '0, '0, 1'b0, dlen, hlen[5:0],
					1'b0, 1'b0, 1'b0);
			end
			push_segment(FLAG_ACK, snd_nxt, 1'b0, 16'd0);
		end
		if ((it.segment_flags & FLAG_FIN) != 0) begin
			tail = it.segment_seq + {16'd0, dlen};
			if (tail == rcv_nxt)
				rcv_nxt += 32'd1;
			push_segment(FLAG_FIN | FLAG_ACK, snd_nxt, 1'b0, 16'd0);
			snd_nxt += 32'd1;
			link_state = LINK_DONE;
			push_event(KIND_CLOSED);
		end
	endtask

	// Expected results of one accepted item, completion last
	task automatic predict_results(input in_item_t it);
		logic acc;
		logic [31:0] elapsed;
		logic [3:0] tries;
		acc = 1'b0;
		case (it.operation)
			OP_CONNECT: begin
				own_port = port_pool;
				port_pool = (port_pool == 16'hFFFF) ? PORT_FIRST : port_pool + 16'd1;
				snd_nxt = {it.now_ticks[23:0], 8'd0} ^ ISN_MIX;
				rcv_nxt = '0;
				link_state = LINK_SYN_SENT;
				syn_stamp = it.now_ticks;
				retry_tally = '0;
				push_segment(FLAG_SYN, snd_nxt, 1'b1, 16'd0);
				snd_nxt += 32'd1;
			end
			OP_WRITE: begin
				if (link_state == LINK_ESTABLISHED && it.length <= MAX_WRITE_BYTES) begin
					push_segment(FLAG_PSH | FLAG_ACK, snd_nxt, 1'b0, it.length);
					snd_nxt += {16'd0, it.length};
					acc = 1'b1;
				end
			end
			OP_CLOSE: begin
				if (link_state == LINK_ESTABLISHED) begin
					push_segment(FLAG_FIN | FLAG_ACK, snd_nxt, 1'b0, 16'd0);
					snd_nxt += 32'd1;
				end
				link_state = LINK_DONE;
			end
			OP_SEGMENT: take_segment(it);
			OP_TICK: begin
				elapsed = it.now_ticks - syn_stamp;
				if (link_state == LINK_SYN_SENT && elapsed >= {16'd0, rto_ticks}) begin
					tries = {1'b0, retry_tally} + 4'd1;
					syn_stamp = it.now_ticks;
					retry_tally = tries[2:0];
					if (tries > {1'b0, rto_limit}) begin
						link_state = LINK_DONE;
						push_event(KIND_CLOSED);
					end else begin
						push_segment(FLAG_SYN, snd_nxt - 32'd1, 1'b1, 16'd0);
					end
				end
			end
			default: ;
		endcase
		push_result(KIND_DONE, '0, '0, '0, 1'b0, '0, '0, acc,
			link_state == LINK_SYN_SENT || link_state == LINK_ESTABLISHED, 1'b1);
	endtask

	// Item builders; fields an operation ignores carry random bits
	function automatic in_item_t random_item();
		in_item_t it;
		it.operation = 3'($urandom_range(0, 7));
		it.now_ticks = $urandom;
		it.length = 16'($urandom);
		it.source_address = $urandom;
		it.source_port = 16'($urandom);
		it.dest_port = 16'($urandom);
		it.segment_seq = $urandom;
		it.segment_flags = 8'($urandom);
		it.offset_words = 4'($urandom);
		return it;
	endfunction

	function automatic in_item_t op_item(input logic [2:0] op, input logic [31:0] now,
			input logic [15:0] len);
		in_item_t it;
		it = random_item();
		it.operation = op;
		it.now_ticks = now;
		it.length = len;
		return it;
	endfunction

	function automatic in_item_t seg_item(input logic [15:0] len, input logic [31:0] seq,
			input logic [7:0] flags, input logic [3:0] off);
		in_item_t it;
		it = random_item();
		it.operation = OP_SEGMENT;
		it.length = len;
		it.source_address = peer_ip;
		it.source_port = rmt_port;
		it.dest_port = own_port;
		it.segment_seq = seq;
		it.segment_flags = flags;
		it.offset_words = off;
		return it;
	endfunction

	// Well-formed segment with a random header length and body
	function automatic in_item_t data_segment(input logic [31:0] seq, input logic [7:0] flags);
		logic [3:0] off;
		logic [15:0] body;
		off = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
		body = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535 - 60))
			: 16'($urandom_range(0, 1460));
		return seg_item({10'd0, off, 2'b00} + body, seq, flags, off);
	endfunction

	// Offer one item, with a random gap before it when idling is on
	task automatic send_item(input in_item_t it);
		if (idle_on && $urandom_range(0, 99) < 25) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.payload <= it;
		do @(posedge clk); while (!in_ch.ready);
		predict_results(it);
		items_sent++;
	endtask

	// Stop offering and wait for every expected result to drain
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (outstanding_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic configure(input logic [31:0] addr, input logic [15:0] port,
			input logic [15:0] intvl, input logic [2:0] lim);
		settle();
		write_reg(REG_PEER_ADDRESS, addr);
		write_reg(REG_RMT_PORT, {16'd0, port});
		write_reg(REG_RETRY_INTVL, {16'd0, intvl});
		write_reg(REG_RETRY_LIMIT, {29'd0, lim});
		cfg_we <= 1'b0;
		peer_ip = addr;
		rmt_port = port;
		rto_ticks = intvl;
		rto_limit = lim;
	endtask

	// Connect and complete the handshake
	task automatic open_link();
		send_item(op_item(OP_CONNECT, $urandom, 16'($urandom)));
		send_item(seg_item(16'd20, $urandom, FLAG_SYN | FLAG_ACK, 4'd5));
	endtask

	// Basic flow under reset register values
	task automatic test_basic_flow();
		send_item(op_item(OP_CONNECT, 32'd0, 16'($urandom)));
		send_item(op_item(OP_WRITE, $urandom, 16'd10));
		send_item(op_item(OP_TICK, 32'd99, 16'($urandom)));
		send_item(op_item(OP_TICK, 32'd100, 16'($urandom)));
		// receive number wraps to zero
		send_item(seg_item(16'd20, 32'hFFFF_FFFF, FLAG_SYN | FLAG_ACK, 4'd5));
		send_item(op_item(OP_WRITE, $urandom, 16'd0));
		send_item(op_item(OP_WRITE, $urandom, MAX_WRITE_BYTES));
		send_item(op_item(OP_WRITE, $urandom, MAX_WRITE_BYTES + 16'd1));
		send_item(op_item(OP_WRITE, $urandom, 16'hFFFF));
		// malformed headers are dropped
		send_item(seg_item(16'd19, rcv_nxt, FLAG_ACK, 4'd4));
		send_item(seg_item(16'd40, rcv_nxt, FLAG_ACK, 4'd4));
		send_item(seg_item(16'd59, rcv_nxt, FLAG_ACK, 4'd15));
		// largest header and largest segment
		send_item(seg_item(16'hFFFF, rcv_nxt, FLAG_PSH | FLAG_ACK, 4'd15));
		send_item(seg_item(16'd30, rcv_nxt + 32'd7, FLAG_ACK, 4'd5));
		send_item(op_item(OP_TICK, 32'hFFFF_FFFF, 16'($urandom)));
		begin
			in_item_t it;
			it = seg_item(16'd30, rcv_nxt, FLAG_ACK, 4'd5);
			it.source_address = peer_ip ^ 32'h8000_0000;
			send_item(it);
			it = seg_item(16'd30, rcv_nxt, FLAG_ACK, 4'd5);
			it.source_port = rmt_port ^ 16'h0001;
			send_item(it);
			it = seg_item(16'd30, rcv_nxt, FLAG_ACK, 4'd5);
			it.dest_port = own_port ^ 16'h8000;
			send_item(it);
		end
		// data with FIN: deliver, ack, fin, closed, completion
		send_item(seg_item(16'd45, rcv_nxt, FLAG_FIN | FLAG_PSH | FLAG_ACK, 4'd5));
		send_item(seg_item(16'd45, rcv_nxt, FLAG_ACK, 4'd5));
		send_item(op_item(3'd5, $urandom, 16'($urandom)));
		send_item(op_item(3'd7, $urandom, 16'($urandom)));
	endtask

	// Close, reset and FIN paths
	task automatic test_teardown();
		configure(32'hFFFF_FFFF, 16'hFFFF, 16'd1, 3'd3);
		send_item(op_item(OP_CLOSE, $urandom, 16'($urandom)));
		send_item(op_item(OP_CONNECT, 32'hFFFF_FFFF, 16'($urandom)));
		send_item(seg_item(16'd20, $urandom, FLAG_SYN, 4'd5));
		send_item(op_item(OP_CLOSE, $urandom, 16'($urandom)));
		open_link();
		send_item(seg_item(16'd20, $urandom, FLAG_SYN | FLAG_ACK, 4'd5));
		send_item(op_item(OP_CLOSE, $urandom, 16'($urandom)));
		open_link();
		send_item(seg_item(16'd20, rcv_nxt, FLAG_RST | FLAG_ACK, 4'd5));
		send_item(op_item(OP_CONNECT, $urandom, 16'($urandom)));
		send_item(seg_item(16'd20, $urandom, 8'hFF, 4'd5));
		open_link();
		send_item(seg_item(16'd20, rcv_nxt + 32'd5, FLAG_FIN | FLAG_ACK, 4'd5));
	endtask

	// SYN retransmission and giving up
	task automatic test_syn_retries();
		logic [31:0] t;
		configure($urandom, 16'($urandom), 16'd0, 3'd0);
		t = $urandom;
		send_item(op_item(OP_CONNECT, t, 16'($urandom)));
		send_item(op_item(OP_TICK, t, 16'($urandom)));
		configure($urandom, 16'($urandom), 16'd0, 3'd2);
		send_item(op_item(OP_CONNECT, t, 16'($urandom)));
		repeat (3) send_item(op_item(OP_TICK, t, 16'($urandom)));
		configure($urandom, 16'($urandom), 16'hFFFF, 3'd7);
		t = 32'hFFFF_FFF0;
		send_item(op_item(OP_CONNECT, t, 16'($urandom)));
		send_item(op_item(OP_TICK, t + 32'd65534, 16'($urandom)));
		repeat (8) begin
			t += 32'd65535;
			send_item(op_item(OP_TICK, t, 16'($urandom)));
		end
		send_item(op_item(OP_TICK, t + 32'd65535, 16'($urandom)));
	endtask

	// Back-to-back connects, each taking the next local port
	task automatic test_port_wrap();
		idle_on = 1'b0;
		repeat (20)
			send_item(op_item(OP_CONNECT, $urandom, 16'($urandom)));
		idle_on = 1'b1;
	endtask

	// Receiver holds off while the sender keeps offering, then sender drains
	task automatic test_backpressure();
		configure($urandom, 16'($urandom), 16'($urandom_range(1, 200)), 3'($urandom));
		open_link();
		hold_request = 1'b1;
		repeat (20) begin
			send_item(op_item(OP_WRITE, $urandom, 16'($urandom_range(0, 1480))));
			send_item(data_segment(rcv_nxt, FLAG_ACK | FLAG_PSH));
		end
		settle();
	endtask

	// One connection lifetime with random content
	task automatic run_session();
		logic [7:0] f;
		send_item(op_item(OP_CONNECT, $urandom, 16'($urandom)));
		repeat ($urandom_range(0, 2))
			send_item(op_item(OP_TICK, syn_stamp + $urandom_range(0, 2 * rto_ticks + 1),
				16'($urandom)));
		if (link_state != LINK_SYN_SENT || $urandom_range(0, 99) < 8)
			return;
		f = 8'($urandom);
		f = (f & ~FLAG_RST) | FLAG_SYN | FLAG_ACK;
		send_item(seg_item(16'd20, $urandom, f, 4'd5));
		repeat ($urandom_range(1, 12)) begin
			f = 8'($urandom);
			f = f & ~(FLAG_RST | FLAG_FIN);
			case ($urandom_range(0, 9))
				0, 1, 2: send_item(op_item(OP_WRITE, $urandom, 16'($urandom_range(0, 1480))));
				3: send_item(op_item(OP_WRITE, $urandom, 16'($urandom_range(1481, 65535))));
				4, 5, 6, 7: send_item(data_segment(rcv_nxt, f));
				8: send_item(op_item(OP_TICK, $urandom, 16'($urandom)));
				default: send_item(data_segment(rcv_nxt + $urandom_range(1, 5000), f));
			endcase
		end
		case ($urandom_range(0, 9))
			0, 1, 2: send_item(op_item(OP_CLOSE, $urandom, 16'($urandom)));
			3, 4: send_item(data_segment(rcv_nxt, FLAG_FIN | FLAG_ACK));
			5: send_item(data_segment($urandom, FLAG_FIN | FLAG_ACK));
			6: send_item(data_segment($urandom, FLAG_RST | 8'($urandom)));
			default: ;
		endcase
	endtask

	// Garbage and near-miss items
	task automatic send_noise();
		in_item_t it;
		it = data_segment(rcv_nxt, FLAG_ACK);
		case ($urandom_range(0, 7))
			0, 1: it = random_item();
			2: it.source_address ^= 32'd1 << $urandom_range(0, 31);
			3: it.source_port ^= 16'd1 << $urandom_range(0, 15);
			4: it.dest_port ^= 16'd1 << $urandom_range(0, 15);
			5: it.offset_words = 4'($urandom_range(0, 4));
			6: it.length = 16'($urandom_range(0, 19));
			default: it = op_item(3'($urandom_range(5, 7)), $urandom, 16'($urandom));
		endcase
		send_item(it);
	endtask

	task automatic run_random(input int count);
		int goal;
		goal = items_sent + count;
		while (items_sent < goal) begin
			if ($urandom_range(0, 99) < 85)
				run_session();
			else
				send_noise();
		end
	endtask

	task automatic test_random_sessions();
		configure($urandom, 16'($urandom), 16'($urandom_range(1, 300)), 3'($urandom));
		idle_on = 1'b0;
		run_random(100);
		idle_on = 1'b1;
		run_random(80);
		configure($urandom, 16'($urandom), 16'($urandom_range(1, 20)), 3'($urandom));
		run_random(170);
	endtask

	// Result receiver: random stalls, one long hold on request
	initial begin
		int hold_left;
		hold_left = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (!idle_on) begin
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= ($urandom_range(0, 99) >= 25);
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// Compare each result with the oldest expectation
	initial begin
		out_item_t want;
		out_item_t got;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.payload;
				if (outstanding_results.size() == 0) begin
					$error("result with nothing expected: kind 0x%0h", got.kind);
					mismatches++;
				end else begin
					want = outstanding_results.pop_front();
					check_field("kind", want.kind, got.kind);
					check_field("tx_flags", want.tx_flags, got.tx_flags);
					check_field("tx_seq", want.tx_seq, got.tx_seq);
					check_field("tx_ack", want.tx_ack, got.tx_ack);
					check_field("tx_with_mss", want.tx_with_mss, got.tx_with_mss);
					check_field("payload_length", want.payload_length, got.payload_length);
					check_field("payload_offset", want.payload_offset, got.payload_offset);
					check_field("own_port", want.own_port, got.own_port);
					check_field("accepted", want.accepted, got.accepted);
					check_field("active", want.active, got.active);
					check_field("last", want.last, got.last);
				end
			end
		end
	end

	// Watchdog: too long with nothing accepted on either side
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL tcp_client_connection_engine");
		$finish;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		reset_model();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_flow();
		test_teardown();
		test_syn_retries();
		test_port_wrap();
		test_backpressure();
		test_random_sessions();

		settle();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding_results.size() == 0)
			$display("PASS tcp_client_connection_engine");
		else
			$display("FAIL tcp_client_connection_engine");
		$finish;
	end
endmodule
